/* rtl/product_except_self_top_defines.svh */
// Assertion macros for the product-except-self block.
// Included by the top level only; relies on aclk and aresetn in the including scope.
`ifndef PRODUCT_EXCEPT_SELF_TOP_DEFINES_SVH
`define PRODUCT_EXCEPT_SELF_TOP_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Implication checked in the cycle after the trigger, outside reset.
`define PES_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pes_pkg.sv */
// Shared types and constants for the product-except-self block.
// No dependencies; used by every module of the block.
`default_nettype none

package pes_pkg;

    // Default vector depth and fixed field widths.
    localparam int MAX_LEN_DEF = 64;
    localparam int DATA_W      = 32;
    localparam int POS_W       = 6;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 40;

    // Neutral element of the product.
    localparam logic [DATA_W-1:0] ONE = 32'd1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUF_RD,
        ST_SUF_MUL,
        ST_SUF_WB,
        ST_EMIT_RD,
        ST_EMIT_MUL,
        ST_EMIT_OUT
    } state_t;

    // Write strobes from the sequencer to the element and product stores.
    typedef struct packed {
        logic elem_we;
        logic pre_we;
        logic suf_we;
    } mem_cmd_t;

endpackage

`default_nettype wire

/* rtl/pes_mul.sv */
// Shared 32 x 32 multiplier with a registered, enabled result (low word only).
// Depends on pes_pkg for the data width.
`default_nettype none

module pes_mul (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [pes_pkg::DATA_W-1:0] a,
    input  wire logic [pes_pkg::DATA_W-1:0] b,
    output logic      [pes_pkg::DATA_W-1:0] p_reg
);

    logic [2*pes_pkg::DATA_W-1:0] full_prod;

    // Full product; only the low word is kept, which wraps modulo 2^32.
    assign full_prod = a * b;

    // The result holds while the unit is not enabled.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= full_prod[pes_pkg::DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/pes_store.sv */
// Element, prefix-product and suffix-product memories, one write and one
// registered read port each. Depends on pes_pkg.
`default_nettype none

module pes_store #(
    parameter  int MAX_LEN = pes_pkg::MAX_LEN_DEF,
    localparam int ADDR_W  = $clog2(MAX_LEN)
) (
    input  wire logic                       aclk,
    input  wire pes_pkg::mem_cmd_t          cmd,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [pes_pkg::DATA_W-1:0] elem_wdata,
    input  wire logic [pes_pkg::DATA_W-1:0] prod_wdata,
    input  wire logic [ADDR_W-1:0]          elem_rd_addr,
    input  wire logic [ADDR_W-1:0]          pre_rd_addr,
    input  wire logic [ADDR_W-1:0]          suf_rd_addr,
    output logic      [pes_pkg::DATA_W-1:0] elem_rd_reg,
    output logic      [pes_pkg::DATA_W-1:0] pre_rd_reg,
    output logic      [pes_pkg::DATA_W-1:0] suf_rd_reg
);

    logic [pes_pkg::DATA_W-1:0] elem_mem [MAX_LEN];
    logic [pes_pkg::DATA_W-1:0] pre_mem  [MAX_LEN];
    logic [pes_pkg::DATA_W-1:0] suf_mem  [MAX_LEN];

    // Element store: written as each element is taken.
    always_ff @(posedge aclk) begin
        if (cmd.elem_we) begin
            elem_mem[wr_addr] <= elem_wdata;
        end
        elem_rd_reg <= elem_mem[elem_rd_addr];
    end

    // Prefix products: written during loading.
    always_ff @(posedge aclk) begin
        if (cmd.pre_we) begin
            pre_mem[wr_addr] <= prod_wdata;
        end
        pre_rd_reg <= pre_mem[pre_rd_addr];
    end

    // Suffix products: written during the backward pass.
    always_ff @(posedge aclk) begin
        if (cmd.suf_we) begin
            suf_mem[wr_addr] <= prod_wdata;
        end
        suf_rd_reg <= suf_mem[suf_rd_addr];
    end

endmodule

`default_nettype wire

/* rtl/pes_ctrl.sv */
// Sequencer for the product-except-self block: load, suffix pass and emit
// pass around one shared multiplier. Depends on pes_pkg.
`default_nettype none

module pes_ctrl #(
    parameter  int MAX_LEN = pes_pkg::MAX_LEN_DEF,
    localparam int ADDR_W  = $clog2(MAX_LEN),
    localparam int CNT_W   = $clog2(MAX_LEN + 1)
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // Input handshake
    input  wire logic                       in_valid,
    input  wire logic                       in_last,
    input  wire logic [pes_pkg::DATA_W-1:0] in_value,
    output logic                            in_ready,
    // Result handshake
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            out_last,
    output logic      [pes_pkg::POS_W-1:0]  out_pos,
    // Shared multiplier
    output logic                            mul_en,
    output logic      [pes_pkg::DATA_W-1:0] mul_a,
    output logic      [pes_pkg::DATA_W-1:0] mul_b,
    input  wire logic [pes_pkg::DATA_W-1:0] mul_p,
    // Stores
    output pes_pkg::mem_cmd_t               mem_cmd,
    output logic      [ADDR_W-1:0]          wr_addr,
    output logic      [ADDR_W-1:0]          elem_rd_addr,
    output logic      [ADDR_W-1:0]          pre_rd_addr,
    output logic      [ADDR_W-1:0]          suf_rd_addr,
    input  wire logic [pes_pkg::DATA_W-1:0] elem_rd,
    input  wire logic [pes_pkg::DATA_W-1:0] pre_rd,
    input  wire logic [pes_pkg::DATA_W-1:0] suf_rd
);

    pes_pkg::state_t            state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           n_reg, n_next;
    logic [ADDR_W-1:0]          idx_reg, idx_next;
    logic                       last_reg, last_next;
    logic [pes_pkg::DATA_W-1:0] run_reg, run_next;

    logic full;
    logic at_end;
    logic at_start;

    assign full     = (count_reg == CNT_W'(MAX_LEN));
    assign at_end   = (CNT_W'(idx_reg) == n_reg - CNT_W'(1));
    assign at_start = (idx_reg == '0);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pes_pkg::ST_IDLE;
            count_reg <= '0;
            n_reg     <= '0;
            idx_reg   <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg     <= n_next;
            idx_reg   <= idx_next;
            last_reg  <= last_next;
        end
    end

    // Running prefix or suffix product.
    always_ff @(posedge aclk) begin
        run_reg <= run_next;
    end

    // Next state, store strobes and multiplier operands.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        run_next     = run_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        mul_en       = 1'b0;
        mul_a        = run_reg;
        mul_b        = in_value;
        mem_cmd      = '0;
        wr_addr      = count_reg[ADDR_W-1:0];
        elem_rd_addr = idx_reg;
        pre_rd_addr  = at_start ? '0 : idx_reg - ADDR_W'(1);
        suf_rd_addr  = at_end ? '0 : idx_reg + ADDR_W'(1);

        case (state_reg)
            pes_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    last_next = in_last;
                    if (!full) begin
                        // Store the element and start its prefix product.
                        mem_cmd.elem_we = 1'b1;
                        mul_en          = 1'b1;
                        mul_a           = (count_reg == '0) ? pes_pkg::ONE : run_reg;
                        state_next      = pes_pkg::ST_LOAD;
                    end else if (in_last) begin
                        // Store full: the marker still closes the run.
                        n_next     = count_reg;
                        idx_next   = ADDR_W'(MAX_LEN - 1);
                        state_next = pes_pkg::ST_SUF_RD;
                    end
                end
            end

            pes_pkg::ST_LOAD: begin
                mem_cmd.pre_we = 1'b1;
                run_next       = mul_p;
                count_next     = count_reg + CNT_W'(1);
                if (last_reg) begin
                    n_next     = count_reg + CNT_W'(1);
                    idx_next   = count_reg[ADDR_W-1:0];
                    state_next = pes_pkg::ST_SUF_RD;
                end else begin
                    state_next = pes_pkg::ST_IDLE;
                end
            end

            pes_pkg::ST_SUF_RD: begin
                state_next = pes_pkg::ST_SUF_MUL;
            end

            pes_pkg::ST_SUF_MUL: begin
                mul_en     = 1'b1;
                mul_a      = at_end ? pes_pkg::ONE : run_reg;
                mul_b      = elem_rd;
                state_next = pes_pkg::ST_SUF_WB;
            end

            pes_pkg::ST_SUF_WB: begin
                mem_cmd.suf_we = 1'b1;
                wr_addr        = idx_reg;
                run_next       = mul_p;
                if (at_start) begin
                    state_next = pes_pkg::ST_EMIT_RD;
                end else begin
                    idx_next   = idx_reg - ADDR_W'(1);
                    state_next = pes_pkg::ST_SUF_RD;
                end
            end

            pes_pkg::ST_EMIT_RD: begin
                state_next = pes_pkg::ST_EMIT_MUL;
            end

            pes_pkg::ST_EMIT_MUL: begin
                // Edges of the vector use the empty product.
                mul_en     = 1'b1;
                mul_a      = at_start ? pes_pkg::ONE : pre_rd;
                mul_b      = at_end ? pes_pkg::ONE : suf_rd;
                state_next = pes_pkg::ST_EMIT_OUT;
            end

            pes_pkg::ST_EMIT_OUT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    if (at_end) begin
                        count_next = '0;
                        state_next = pes_pkg::ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = pes_pkg::ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = pes_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_last = at_end;
    assign out_pos  = pes_pkg::POS_W'(idx_reg);

endmodule

`default_nettype wire

/* rtl/product_except_self_top.sv */
// Product of all other elements of a vector: a streaming channel in, a
// streaming channel out. Top level; depends on pes_pkg, pes_ctrl, pes_store,
// pes_mul and the assertion macros in product_except_self_top_defines.svh.
//
// Usage:
//   s_ channel: one signed 32-bit element per transfer, s_tlast on the final
//   element of the vector. Up to MAX_LEN elements are held; further elements
//   are dropped, but their tlast still closes the run.
//   m_ channel: one result per held element, in index order; tdata carries
//   the product of all other elements (mod 2^32) and the low 6 bits of the
//   index; m_tlast marks the final result of the run. A one-element vector
//   yields the product 1.
// Sequence (all work goes through one registered 32 x 32 multiplier):
//   loading stores each element, then writes its prefix product; a dropped
//   element is only taken; after the final element, the suffix pass reads,
//   multiplies and writes back one suffix product per element, last first;
//   each result is then read, multiplied and offered until m_tready takes it.
// s_tready is low from a final element until the last result is taken.
// A stalled result holds steady on m_ until m_tready rises.
// Reset (aresetn low, synchronous) empties the element count and idles the
// sequencer; store contents are not cleared.
`default_nettype none
`include "product_except_self_top_defines.svh"

module product_except_self_top #(
    parameter int MAX_LEN = pes_pkg::MAX_LEN_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [pes_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic                          s_tlast,  // is_last
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [pes_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] product, [37:32] position
    output logic                               m_tlast   // last_result
);

    localparam int ADDR_W = $clog2(MAX_LEN);

    pes_pkg::mem_cmd_t          mem_cmd;
    logic [ADDR_W-1:0]          wr_addr;
    logic [ADDR_W-1:0]          elem_rd_addr;
    logic [ADDR_W-1:0]          pre_rd_addr;
    logic [ADDR_W-1:0]          suf_rd_addr;
    logic [pes_pkg::DATA_W-1:0] elem_rd;
    logic [pes_pkg::DATA_W-1:0] pre_rd;
    logic [pes_pkg::DATA_W-1:0] suf_rd;
    logic                       mul_en;
    logic [pes_pkg::DATA_W-1:0] mul_a;
    logic [pes_pkg::DATA_W-1:0] mul_b;
    logic [pes_pkg::DATA_W-1:0] mul_p;
    logic [pes_pkg::POS_W-1:0]  out_pos;

    // Sequencer.
    pes_ctrl #(
        .MAX_LEN (MAX_LEN)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_last      (s_tlast),
        .in_value     (s_tdata[pes_pkg::DATA_W-1:0]),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_last     (m_tlast),
        .out_pos      (out_pos),
        .mul_en       (mul_en),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p),
        .mem_cmd      (mem_cmd),
        .wr_addr      (wr_addr),
        .elem_rd_addr (elem_rd_addr),
        .pre_rd_addr  (pre_rd_addr),
        .suf_rd_addr  (suf_rd_addr),
        .elem_rd      (elem_rd),
        .pre_rd       (pre_rd),
        .suf_rd       (suf_rd)
    );

    // Element and product stores.
    pes_store #(
        .MAX_LEN (MAX_LEN)
    ) u_store (
        .aclk         (aclk),
        .cmd          (mem_cmd),
        .wr_addr      (wr_addr),
        .elem_wdata   (s_tdata[pes_pkg::DATA_W-1:0]),
        .prod_wdata   (mul_p),
        .elem_rd_addr (elem_rd_addr),
        .pre_rd_addr  (pre_rd_addr),
        .suf_rd_addr  (suf_rd_addr),
        .elem_rd_reg  (elem_rd),
        .pre_rd_reg   (pre_rd),
        .suf_rd_reg   (suf_rd)
    );

    // Shared multiplier; its held result is also the output product.
    pes_mul u_mul (
        .aclk  (aclk),
        .en    (mul_en),
        .a     (mul_a),
        .b     (mul_b),
        .p_reg (mul_p)
    );

    // Pack the result fields, lowest first, padded to whole bytes.
    assign m_tdata = {
        (pes_pkg::M_TDATA_W - pes_pkg::DATA_W - pes_pkg::POS_W)'(0),
        out_pos,
        mul_p
    };

    // The block never takes an element while a result is on offer.
    `PES_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input ready while result pending")

    // A final element always starts the backward pass.
    `PES_ASSERT_NEXT(a_busy_after_last, s_tvalid && s_tready && s_tlast, !s_tready,
        "still ready after final element")

    // Taking the final result returns the block to loading.
    `PES_ASSERT_NEXT(a_idle_after_run, m_tvalid && m_tready && m_tlast,
        s_tready && !m_tvalid, "not idle after final result")

endmodule

`default_nettype wire
